>>> rtl/bdeq_pkg.sv
// shared types and constants for the bounded double-ended queue
// used by bdeq_ctrl, bdeq_dp and bounded_double_ended_queue_unit
package bdeq_pkg;

    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ       = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_LOAD = 2'd2
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic exec;   // apply the accepted command to the store and indices
        logic load;   // move read data into the output registers
    } dp_ctrl_t;

endpackage

>>> rtl/bounded_double_ended_queue_unit.sv
// bounded double-ended queue of 32-bit words, 16 slots, one command per word
// an accepted word passes through a registered read of both ends, then a load into the output
// registers that waits until the output register is free; a new word is taken only in idle
// state, after that load, while the previous result may still wait in the output register
// reset clears front index, entry count and handshake state; the slot store is not cleared
module bounded_double_ended_queue_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bdeq_pkg::CMD_W-1:0]    command,
    input  logic [bdeq_pkg::WORD_BITS-1:0] data_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bdeq_pkg::WORD_BITS-1:0] front_value,
    output logic [bdeq_pkg::WORD_BITS-1:0] back_value,
    output logic [bdeq_pkg::CNT_W-1:0]    entry_count_out,
    output logic                          is_empty,
    output logic [bdeq_pkg::STAT_W-1:0]   status
);
    import bdeq_pkg::*;

    dp_ctrl_t dp_ctrl;

    // sequencer
    bdeq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_ctrl   (dp_ctrl)
    );

    // store and result datapath
    bdeq_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_ctrl         (dp_ctrl),
        .command         (command),
        .data_in         (data_in),
        .front_value     (front_value),
        .back_value      (back_value),
        .entry_count_out (entry_count_out),
        .is_empty        (is_empty),
        .status          (status)
    );

endmodule

>>> rtl/bdeq_ctrl.sv
// sequencer for the queue: accept, read back the ends, load the result word
// depends on bdeq_pkg
module bdeq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output bdeq_pkg::dp_ctrl_t dp_ctrl
);
    import bdeq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // state and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        dp_ctrl.exec   = 1'b0;
        dp_ctrl.load   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_ctrl.exec = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    dp_ctrl.load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/bdeq_dp.sv
// datapath: circular slot store, front index, entry count and result registers
// depends on bdeq_pkg
module bdeq_dp
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bdeq_pkg::dp_ctrl_t       dp_ctrl,
    input  logic [bdeq_pkg::CMD_W-1:0] command,
    input  bdeq_pkg::word_t          data_in,
    output bdeq_pkg::word_t          front_value,
    output bdeq_pkg::word_t          back_value,
    output bdeq_pkg::cnt_t           entry_count_out,
    output logic                     is_empty,
    output logic [bdeq_pkg::STAT_W-1:0] status
);
    import bdeq_pkg::*;

    word_t slot_mem [CAPACITY];

    idx_t  front_reg;
    idx_t  front_next;
    cnt_t  count_reg;
    cnt_t  count_next;
    stat_t stat_reg;
    stat_t stat_next;

    logic  wr_en;
    idx_t  wr_addr;
    idx_t  back_addr;

    word_t rd_front_reg;
    word_t rd_back_reg;

    word_t front_value_reg;
    word_t back_value_reg;
    cnt_t  count_out_reg;
    logic  empty_reg;
    stat_t stat_out_reg;

    logic  full;
    logic  empty;

    assign full  = (count_reg == cnt_t'(CAPACITY));
    assign empty = (count_reg == '0);

    // command decode and index update
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        stat_next  = ST_DONE;
        wr_en      = 1'b0;
        wr_addr    = front_reg + count_reg[IDX_W-1:0];
        unique case (command)
            CMD_PUSH_FRONT:
            begin
                if (full)
                    stat_next = ST_FULL;
                else
                begin
                    front_next = front_reg - idx_t'(1);
                    wr_addr    = front_reg - idx_t'(1);
                    wr_en      = 1'b1;
                    count_next = count_reg + cnt_t'(1);
                end
            end
            CMD_PUSH_BACK:
            begin
                if (full)
                    stat_next = ST_FULL;
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + cnt_t'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                    stat_next = ST_EMPTY;
                else
                begin
                    front_next = front_reg + idx_t'(1);
                    count_next = count_reg - cnt_t'(1);
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                    stat_next = ST_EMPTY;
                else
                    count_next = count_reg - cnt_t'(1);
            end
            default:
            begin
                // read only, unused codes too
                stat_next = ST_DONE;
            end
        endcase
    end

    // queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            stat_reg  <= ST_DONE;
        end
        else if (dp_ctrl.exec)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            stat_reg  <= stat_next;
        end
    end

    // slot store write
    always_ff @(posedge clk)
    begin
        if (dp_ctrl.exec && wr_en)
            slot_mem[wr_addr] <= data_in;
    end

    // registered reads of both ends
    assign back_addr = front_reg + count_reg[IDX_W-1:0] - idx_t'(1);

    always_ff @(posedge clk)
    begin
        rd_front_reg <= slot_mem[front_reg];
        rd_back_reg  <= slot_mem[back_addr];
    end

    // result word registers
    always_ff @(posedge clk)
    begin
        if (dp_ctrl.load)
        begin
            front_value_reg <= empty ? '0 : rd_front_reg;
            back_value_reg  <= empty ? '0 : rd_back_reg;
            count_out_reg   <= count_reg;
            empty_reg       <= empty;
            stat_out_reg    <= stat_reg;
        end
    end

    assign front_value     = front_value_reg;
    assign back_value      = back_value_reg;
    assign entry_count_out = count_out_reg;
    assign is_empty        = empty_reg;
    assign status          = stat_out_reg;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// testbench for bounded_double_ended_queue_unit: directed, back-pressure and random tests
// depends on rtl/bdeq_pkg.sv and rtl/bounded_double_ended_queue_unit.sv
module tb;

    import bdeq_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned REPORT_LIMIT = 40;
    localparam int unsigned RANDOM_WORDS = 360;
    localparam int unsigned EXP_DEPTH    = 16;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // one expected result word
    typedef struct packed {
        word_t      front;
        word_t      back;
        cnt_t       count;
        logic       empty;
        stat_t      status;
    } deq_view_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     command = CMD_READ;
    word_t                data_in = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    word_t                front_value;
    word_t                back_value;
    cnt_t                 entry_count_out;
    logic                 is_empty;
    logic [STAT_W-1:0]    status;

    // shadow copy of the queue contents
    word_t                slot_copy [CAPACITY];
    int unsigned          head_pos = 0;
    int unsigned          fill_cnt = 0;

    // expected result words in order, running write and read counts
    deq_view_t            exp_fifo [EXP_DEPTH];
    int unsigned          exp_wr = 0;
    int unsigned          exp_rd = 0;
    int unsigned          error_cnt = 0;
    int unsigned          cycle_cnt = 0;

    // sender burst control
    bit                   gaps_on = 1'b1;
    int unsigned          burst_left = 0;

    // receiver stall control
    rx_mode_t             rx_mode = RX_RANDOM;
    logic [15:0]          stall_pattern = 16'hb5d3;
    int unsigned          stall_phase = 0;
    bit                   hold_req = 1'b0;
    int unsigned          hold_left = 0;

    bounded_double_ended_queue_unit i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .data_in         (data_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .front_value     (front_value),
        .back_value      (back_value),
        .entry_count_out (entry_count_out),
        .is_empty        (is_empty),
        .status          (status)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("bounded_double_ended_queue_unit regression: fail");
            $finish;
        end
    end

    // apply one command to the shadow queue and return the view after it
    function automatic deq_view_t deque_apply(input logic [CMD_W-1:0] cmd, input word_t data);
        deq_view_t view;
        view        = '0;
        view.status = ST_DONE;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (fill_cnt >= CAPACITY)
                    view.status = ST_FULL;
                else
                begin
                    if (cmd == CMD_PUSH_FRONT)
                    begin
                        head_pos            = (head_pos + CAPACITY - 1) % CAPACITY;
                        slot_copy[head_pos] = data;
                    end
                    else
                        slot_copy[(head_pos + fill_cnt) % CAPACITY] = data;
                    fill_cnt++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (fill_cnt == 0)
                    view.status = ST_EMPTY;
                else
                begin
                    if (cmd == CMD_POP_FRONT)
                        head_pos = (head_pos + 1) % CAPACITY;
                    fill_cnt--;
                end
            end
            // read only, including the unused codes
            default: ;
        endcase
        if (fill_cnt != 0)
        begin
            view.front = slot_copy[head_pos];
            view.back  = slot_copy[(head_pos + fill_cnt - 1) % CAPACITY];
        end
        view.count = cnt_t'(fill_cnt);
        view.empty = (fill_cnt == 0);
        return view;
    endfunction

    // data pattern with extra weight on edge values
    function automatic word_t random_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return word_t'(1) << $urandom_range(0, WORD_BITS - 1);
            3: return ~(word_t'(1) << $urandom_range(0, WORD_BITS - 1));
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic report_error(input string what, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
        error_cnt++;
        if (error_cnt <= REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, exp_val,
                     act_val);
    endtask

    // send one word, bursts with random gaps in between
    task automatic send_word(input logic [CMD_W-1:0] cmd, input word_t data);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        command  <= cmd;
        data_in  <= data;
        do
            @(posedge clk);
        while (!in_ready);
        exp_fifo[exp_wr % EXP_DEPTH] = deque_apply(cmd, data);
        exp_wr++;
        @(negedge clk);
    endtask

    // receiver: long hold-off on request, otherwise the current stall mode
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:  out_ready <= 1'b1;
                RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
                default:    out_ready <= stall_pattern[stall_phase % 16];
            endcase
            stall_phase++;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        deq_view_t exp_v;
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_wr == exp_rd)
            begin
                error_cnt++;
                if (error_cnt <= REPORT_LIMIT)
                    $display("%0t ns: unexpected result word, front %h back %h count %0d",
                             $time, front_value, back_value, entry_count_out);
            end
            else
            begin
                exp_v = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (front_value !== exp_v.front)
                    report_error("front_value", exp_v.front, front_value);
                if (back_value !== exp_v.back)
                    report_error("back_value", exp_v.back, back_value);
                if (entry_count_out !== exp_v.count)
                    report_error("entry_count_out", 32'(exp_v.count), 32'(entry_count_out));
                if (is_empty !== exp_v.empty)
                    report_error("is_empty", 32'(exp_v.empty), 32'(is_empty));
                if (status !== exp_v.status)
                    report_error("status", 32'(exp_v.status), 32'(status));
            end
        end
    end

    // empty-queue reads and pops, pushes at both ends, unused codes, single entry
    task automatic test_directed();
        gaps_on = 1'b1;
        rx_mode = RX_RANDOM;
        send_word(CMD_READ, 32'h1234_5678);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '1);
        send_word(CMD_PUSH_FRONT, 32'h0000_0000);
        send_word(CMD_PUSH_BACK, 32'hffff_ffff);
        send_word(CMD_PUSH_FRONT, 32'h8000_0001);
        send_word(3'd5, 32'hdead_beef);
        send_word(3'd6, '0);
        send_word(3'd7, '1);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_PUSH_BACK, 32'ha5a5_5a5a);
        send_word(CMD_POP_FRONT, '0);
    endtask

    // receiver holds off while pushes keep coming, so the input stalls
    task automatic test_output_holdoff();
        logic [CMD_W-1:0] cmd;
        gaps_on  = 1'b0;
        rx_mode  = RX_ALWAYS;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            cmd = ($urandom_range(0, 3) != 0) ? ($urandom_range(0, 1) ? CMD_PUSH_BACK
                                                                       : CMD_PUSH_FRONT)
                                              : CMD_POP_FRONT;
            send_word(cmd, random_word());
        end
    endtask

    // segments biased toward filling or draining, with random idling
    task automatic test_random_traffic(input int unsigned n_words);
        int unsigned      sent;
        int unsigned      seg_len;
        int unsigned      push_pct;
        logic [CMD_W-1:0] cmd;
        sent = 0;
        while (sent < n_words)
        begin
            seg_len       = $urandom_range(8, 40);
            push_pct      = $urandom_range(0, 1) ? 75 : 25;
            gaps_on       = ($urandom_range(0, 3) != 0);
            rx_mode       = rx_mode_t'($urandom_range(0, 2));
            // at least one ready slot per pattern period
            stall_pattern = 16'($urandom) | 16'h0001;
            for (int i = 0; i < seg_len && sent < n_words; i++)
            begin
                if ($urandom_range(0, 99) < 8)
                    cmd = 3'($urandom_range(CMD_READ, 7));
                else if ($urandom_range(0, 99) < push_pct)
                    cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else
                    cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
                send_word(cmd, random_word());
                sent++;
            end
        end
    endtask

    // main sequence
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_output_holdoff();
        test_random_traffic(RANDOM_WORDS);

        in_valid <= 1'b0;
        rx_mode  = RX_RANDOM;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_cnt == 0)
            $display("bounded_double_ended_queue_unit regression: pass");
        else
            $display("bounded_double_ended_queue_unit regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/bdeq_pkg.sv
rtl/bdeq_ctrl.sv
rtl/bdeq_dp.sv
rtl/bounded_double_ended_queue_unit.sv
verif/tb.sv
